// ----- rtl/rlt_pkg.sv -----
package rlt_pkg;

  localparam int unsigned SeqW   = 16;
  localparam int unsigned PayW   = 16;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned CntW   = 32;
  localparam int unsigned WpktW  = 17;
  localparam int unsigned InfoW  = 36;
  localparam int unsigned EntryW = TimeW + InfoW;
  localparam int unsigned InW    = SeqW + PayW + TimeW;
  localparam int unsigned InDataW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW   = SeqW + 8 * CntW + WpktW;
  localparam int unsigned OutDataW = ((OutW + 7) / 8) * 8;
  localparam int unsigned CfgIdxW = 2;

  // entry_info flag bits above seq and payload
  localparam int unsigned FlRcv  = 32;
  localparam int unsigned FlMiss = 33;
  localparam int unsigned FlDisc = 34;
  localparam int unsigned FlLost = 35;

  localparam logic [CfgW-1:0] DiscardReset = 24'd300000;
  localparam logic [CfgW-1:0] LoseReset    = 24'd1000000;
  localparam logic [CfgW-1:0] WindowReset  = 24'd1000000;

  localparam logic [SeqW-1:0] WrapHigh = 16'd65472;
  localparam logic [SeqW-1:0] WrapLow  = 16'd128;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DISCARD = 2'd0,
    REG_LOSE    = 2'd1,
    REG_WINDOW  = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_COUNT,
    CMD_RD_DISC,
    CMD_EV_DISC,
    CMD_RD_MISS,
    CMD_EV_MISS,
    CMD_RD_WIN,
    CMD_EV_WIN,
    CMD_RD_START,
    CMD_EV_FORCE,
    CMD_PUSH,
    CMD_FINISH,
    CMD_LD_INIT,
    CMD_RD_LP,
    CMD_EV_LM,
    CMD_EV_LD,
    CMD_REPORT
  } cmd_e;

  typedef struct packed {
    logic is_clear;
    logic late;
    logic disc_pend;
    logic miss_pend;
    logic win_pend;
    logic lp_pend;
    logic full;
    logic gap_left;
    logic stop_disc;
    logic stop_miss;
    logic stop_win;
    logic match_m;
    logic match_d;
    logic out_free;
  } rlt_status_t;

  function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                              input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  function automatic logic aged(input logic [TimeW-1:0] t, input logic [CfgW-1:0] limit,
                                input logic [TimeW-1:0] now);
    return ({1'b0, t} + {{(TimeW + 1 - CfgW){1'b0}}, limit}) < {1'b0, now};
  endfunction

endpackage

// ----- rtl/rlt_ctrl.sv -----
module rlt_ctrl
  import rlt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rlt_status_t st_i,
  output cmd_e        cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_DECODE = 18'h00002,
    S_SD_RD  = 18'h00004,
    S_SD_EV  = 18'h00008,
    S_SM_RD  = 18'h00010,
    S_SM_EV  = 18'h00020,
    S_SW_RD  = 18'h00040,
    S_SW_EV  = 18'h00080,
    S_PU_CHK = 18'h00100,
    S_FO_RD  = 18'h00200,
    S_FO_EV  = 18'h00400,
    S_PU_WR  = 18'h00800,
    S_FINISH = 18'h01000,
    S_LM_RD  = 18'h02000,
    S_LM_EV  = 18'h04000,
    S_LD_RD  = 18'h08000,
    S_LD_EV  = 18'h10000,
    S_REPORT = 18'h20000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st_i.is_clear) begin
          cmd_o   = CMD_CLEAR;
          state_d = S_REPORT;
        end else begin
          cmd_o   = CMD_COUNT;
          state_d = st_i.late ? S_LM_RD : S_SD_RD;
        end
      end
      S_SD_RD: begin
        if (st_i.disc_pend) begin
          cmd_o   = CMD_RD_DISC;
          state_d = S_SD_EV;
        end else begin
          state_d = S_SM_RD;
        end
      end
      S_SD_EV: begin
        cmd_o   = CMD_EV_DISC;
        state_d = st_i.stop_disc ? S_SM_RD : S_SD_RD;
      end
      S_SM_RD: begin
        if (st_i.miss_pend) begin
          cmd_o   = CMD_RD_MISS;
          state_d = S_SM_EV;
        end else begin
          state_d = S_SW_RD;
        end
      end
      S_SM_EV: begin
        cmd_o   = CMD_EV_MISS;
        state_d = st_i.stop_miss ? S_SW_RD : S_SM_RD;
      end
      S_SW_RD: begin
        if (st_i.win_pend) begin
          cmd_o   = CMD_RD_WIN;
          state_d = S_SW_EV;
        end else begin
          state_d = S_PU_CHK;
        end
      end
      S_SW_EV: begin
        cmd_o   = CMD_EV_WIN;
        state_d = st_i.stop_win ? S_PU_CHK : S_SW_RD;
      end
      S_PU_CHK: begin
        state_d = st_i.full ? S_FO_RD : S_PU_WR;
      end
      S_FO_RD: begin
        cmd_o   = CMD_RD_START;
        state_d = S_FO_EV;
      end
      S_FO_EV: begin
        cmd_o   = CMD_EV_FORCE;
        state_d = S_PU_WR;
      end
      S_PU_WR: begin
        cmd_o   = CMD_PUSH;
        state_d = st_i.gap_left ? S_PU_CHK : S_FINISH;
      end
      S_FINISH: begin
        cmd_o   = CMD_FINISH;
        state_d = S_REPORT;
      end
      S_LM_RD: begin
        if (st_i.lp_pend) begin
          cmd_o   = CMD_RD_LP;
          state_d = S_LM_EV;
        end else begin
          cmd_o   = CMD_LD_INIT;
          state_d = S_LD_RD;
        end
      end
      S_LM_EV: begin
        cmd_o   = CMD_EV_LM;
        state_d = st_i.match_m ? S_REPORT : S_LM_RD;
      end
      S_LD_RD: begin
        if (st_i.lp_pend) begin
          cmd_o   = CMD_RD_LP;
          state_d = S_LD_EV;
        end else begin
          state_d = S_REPORT;
        end
      end
      S_LD_EV: begin
        cmd_o   = CMD_EV_LD;
        state_d = st_i.match_d ? S_REPORT : S_LD_RD;
      end
      S_REPORT: begin
        if (st_i.out_free) begin
          cmd_o   = CMD_REPORT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/rlt_datapath.sv -----
module rlt_datapath
  import rlt_pkg::*;
#(
  parameter int unsigned TRACK_DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  output rlt_status_t         st_o,
  input  logic                in_user_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int unsigned AW = $clog2(TRACK_DEPTH);
  localparam int unsigned PW = AW + 1;
  localparam logic [PW-1:0] Depth = PW'(TRACK_DEPTH);
  localparam logic [PW:0]   TwoDepth = (PW + 1)'(2 * TRACK_DEPTH);
  localparam logic [PW-1:0] LastPos = PW'(2 * TRACK_DEPTH - 1);

  function automatic logic [AW-1:0] slot(input logic [PW-1:0] pos);
    logic [PW-1:0] s;
    s = (pos >= Depth) ? pos - Depth : pos;
    return s[AW-1:0];
  endfunction

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] pos);
    return (pos == LastPos) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_dist(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
    logic [PW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[PW]) begin
      d = d + TwoDepth;
    end
    return d[PW-1:0];
  endfunction

  logic [EntryW-1:0] mem_q [TRACK_DEPTH];
  logic [EntryW-1:0] rdata_q;
  logic [AW-1:0]     rslot_q, rd_slot;
  logic              we;
  logic [AW-1:0]     wslot;
  logic [EntryW-1:0] wdata;

  logic [CfgW-1:0] cfg_disc_q, cfg_disc_d, cfg_lose_q, cfg_lose_d, cfg_win_q, cfg_win_d;
  logic            op_q, op_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic [PayW-1:0] pay_q, pay_d;
  logic [TimeW-1:0] now_q, now_d;

  logic [PW-1:0] win_head_q, win_head_d, miss_head_q, miss_head_d;
  logic [PW-1:0] disc_head_q, disc_head_d, tail_q, tail_d, lp_q, lp_d;
  logic [SeqW-1:0] highest_q, highest_d, seq_next_q, seq_next_d;
  logic            started_q, started_d;
  logic [14:0]     gap_q, gap_d;

  logic [CntW-1:0] wraps_q, wraps_d, rcvd_q, rcvd_d, payt_q, payt_d;
  logic [CntW-1:0] lost_q, lost_d, dol_q, dol_d, late_q, late_d, lbyt_q, lbyt_d;
  logic [CntW-1:0] wbytes_q, wbytes_d;
  logic [PW-1:0]   wpkt_q, wpkt_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [InfoW-1:0] info, info1, info2;
  logic [TimeW-1:0] etime;
  logic [PayW-1:0]  epay;
  logic [SeqW-1:0]  diff;
  logic             newer, pend_miss, good;
  logic [PW-1:0]    dw, dm, dd, dmax;
  logic [PW-1:0]    start;

  assign info  = rdata_q[InfoW-1:0];
  assign etime = rdata_q[EntryW-1:InfoW];
  assign epay  = info[31:16];
  assign good  = !info[FlMiss] && !info[FlDisc];
  assign pend_miss = info[FlMiss] && !info[FlDisc] && !info[FlRcv];

  assign diff  = seq_q - highest_q;
  assign newer = (diff != '0) && !diff[SeqW-1];

  assign dw = ring_dist(tail_q, win_head_q);
  assign dm = ring_dist(tail_q, miss_head_q);
  assign dd = ring_dist(tail_q, disc_head_q);

  // oldest head is the one farthest behind the tail
  always_comb begin
    dmax  = dw;
    start = win_head_q;
    if (dm > dmax) begin
      dmax  = dm;
      start = miss_head_q;
    end
    if (dd > dmax) begin
      dmax  = dd;
      start = disc_head_q;
    end
  end

  always_comb begin
    st_o.is_clear  = op_q;
    st_o.late      = started_q && !newer;
    st_o.disc_pend = (dd != '0);
    st_o.miss_pend = (dm != '0);
    st_o.win_pend  = (dw != '0);
    st_o.lp_pend   = (ring_dist(tail_q, lp_q) != '0);
    st_o.full      = (dmax == Depth);
    st_o.gap_left  = (gap_q != '0);
    st_o.stop_disc = (info[FlDisc] && !info[FlRcv] && !aged(etime, cfg_lose_q, now_q)) ||
                     (!info[FlDisc] && info[FlMiss] && !info[FlRcv]);
    st_o.stop_miss = pend_miss && !aged(etime, cfg_disc_q, now_q);
    st_o.stop_win  = !aged(etime, cfg_win_q, now_q);
    st_o.match_m   = info[FlMiss] && !info[FlDisc] && (info[SeqW-1:0] == seq_q);
    st_o.match_d   = info[FlDisc] && (info[SeqW-1:0] == seq_q);
    st_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    cfg_disc_d = cfg_disc_q;
    cfg_lose_d = cfg_lose_q;
    cfg_win_d  = cfg_win_q;
    op_d = op_q;
    seq_d = seq_q;
    pay_d = pay_q;
    now_d = now_q;
    win_head_d = win_head_q;
    miss_head_d = miss_head_q;
    disc_head_d = disc_head_q;
    tail_d = tail_q;
    lp_d = lp_q;
    highest_d = highest_q;
    seq_next_d = seq_next_q;
    started_d = started_q;
    gap_d = gap_q;
    wraps_d = wraps_q;
    rcvd_d = rcvd_q;
    payt_d = payt_q;
    lost_d = lost_q;
    dol_d = dol_q;
    late_d = late_q;
    lbyt_d = lbyt_q;
    wbytes_d = wbytes_q;
    wpkt_d = wpkt_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_slot = rslot_q;
    we = 1'b0;
    wslot = rslot_q;
    wdata = rdata_q;
    info1 = info;
    info2 = info;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DISCARD: cfg_disc_d = cfg_data_i;
        REG_LOSE:    cfg_lose_d = cfg_data_i;
        REG_WINDOW:  cfg_win_d  = cfg_data_i;
        default: ;
      endcase
    end

    unique case (cmd_i) inside
      CMD_LOAD: begin
        op_d  = in_user_i;
        seq_d = in_data_i[SeqW-1:0];
        pay_d = in_data_i[SeqW+PayW-1:SeqW];
        now_d = in_data_i[InW-1:SeqW+PayW];
      end
      CMD_CLEAR: begin
        wraps_d = '0;
        rcvd_d = '0;
        payt_d = '0;
        lost_d = '0;
        dol_d = '0;
        late_d = '0;
        lbyt_d = '0;
        wbytes_d = '0;
        wpkt_d = '0;
        highest_d = '0;
        started_d = 1'b0;
        win_head_d = tail_q;
        miss_head_d = tail_q;
        disc_head_d = tail_q;
      end
      CMD_COUNT: begin
        rcvd_d = sat_add(rcvd_q, 32'd1);
        payt_d = sat_add(payt_q, 32'(pay_q));
        gap_d = (started_q && newer) ? 15'(diff - 16'd1) : '0;
        seq_next_d = highest_q + 16'd1;
        lp_d = miss_head_q;
      end
      CMD_RD_DISC: rd_slot = slot(disc_head_q);
      CMD_EV_DISC: begin
        if (!st_o.stop_disc) begin
          if (info[FlDisc] && !info[FlRcv]) begin
            we = 1'b1;
            info1[FlLost] = 1'b1;
            wdata = {etime, info1};
            lost_d = sat_add(lost_q, 32'd1);
          end
          disc_head_d = pos_inc(disc_head_q);
        end
      end
      CMD_RD_MISS: rd_slot = slot(miss_head_q);
      CMD_EV_MISS: begin
        if (!st_o.stop_miss) begin
          if (pend_miss) begin
            we = 1'b1;
            info1[FlDisc] = 1'b1;
            wdata = {etime, info1};
            dol_d = sat_add(dol_q, 32'd1);
          end
          miss_head_d = pos_inc(miss_head_q);
        end
      end
      CMD_RD_WIN: rd_slot = slot(win_head_q);
      CMD_EV_WIN: begin
        if (!st_o.stop_win) begin
          if (good) begin
            if (wpkt_q != '0) wpkt_d = wpkt_q - 1'b1;
            wbytes_d = (wbytes_q >= 32'(epay)) ? wbytes_q - 32'(epay) : '0;
          end
          win_head_d = pos_inc(win_head_q);
        end
      end
      CMD_RD_START: rd_slot = slot(start);
      CMD_EV_FORCE: begin
        // evict the oldest entry from every scan that still points at it
        if (dw == dmax) begin
          if (good) begin
            if (wpkt_q != '0) wpkt_d = wpkt_q - 1'b1;
            wbytes_d = (wbytes_q >= 32'(epay)) ? wbytes_q - 32'(epay) : '0;
          end
          win_head_d = pos_inc(win_head_q);
        end
        if (dm == dmax) begin
          if (pend_miss) begin
            info1[FlDisc] = 1'b1;
            dol_d = sat_add(dol_q, 32'd1);
          end
          miss_head_d = pos_inc(miss_head_q);
        end
        info2 = info1;
        if (dd == dmax) begin
          if (info1[FlDisc] && !info1[FlRcv] && !info1[FlLost]) begin
            info2[FlLost] = 1'b1;
            lost_d = sat_add(lost_q, 32'd1);
          end
          disc_head_d = pos_inc(disc_head_q);
        end
        we = 1'b1;
        wdata = {etime, info2};
      end
      CMD_PUSH: begin
        we = 1'b1;
        wslot = slot(tail_q);
        if (gap_q != '0) begin
          info1 = {4'b0000, 16'd0, seq_next_q};
          if (cfg_disc_q != '0) begin
            info1[FlMiss] = 1'b1;
          end else begin
            info1[FlDisc] = 1'b1;
            dol_d = sat_add(dol_q, 32'd1);
          end
          gap_d = gap_q - 1'b1;
          seq_next_d = seq_next_q + 16'd1;
        end else begin
          info1 = {4'b0001, pay_q, seq_q};
          wpkt_d = wpkt_q + 1'b1;
          wbytes_d = wbytes_q + 32'(pay_q);
        end
        wdata = {now_q, info1};
        tail_d = pos_inc(tail_q);
      end
      CMD_FINISH: begin
        if (started_q && (highest_q > WrapHigh) && (seq_q < WrapLow)) begin
          wraps_d = sat_add(wraps_q, 32'd1);
        end
        highest_d = seq_q;
        started_d = 1'b1;
      end
      CMD_LD_INIT: lp_d = disc_head_q;
      CMD_RD_LP: rd_slot = slot(lp_q);
      CMD_EV_LM, CMD_EV_LD: begin
        if ((cmd_i == CMD_EV_LM) ? st_o.match_m : st_o.match_d) begin
          we = 1'b1;
          info1[31:16] = pay_q;
          info1[FlRcv] = 1'b1;
          wdata = {etime, info1};
          if (cmd_i == CMD_EV_LD) begin
            late_d = sat_add(late_q, 32'd1);
            lbyt_d = sat_add(lbyt_q, 32'(pay_q));
          end
        end else begin
          lp_d = pos_inc(lp_q);
        end
      end
      CMD_REPORT: begin
        out_valid_d = 1'b1;
        out_data_d = OutDataW'({lbyt_q, late_q, dol_q, lost_q, wbytes_q,
                                WpktW'(wpkt_q), payt_q, rcvd_q, wraps_q, highest_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wslot] <= wdata;
    end
    rdata_q <= mem_q[rd_slot];
    rslot_q <= rd_slot;
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    seq_q <= seq_d;
    pay_q <= pay_d;
    now_q <= now_d;
    seq_next_q <= seq_next_d;
    gap_q <= gap_d;
    lp_q <= lp_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_disc_q <= DiscardReset;
      cfg_lose_q <= LoseReset;
      cfg_win_q  <= WindowReset;
      win_head_q <= '0;
      miss_head_q <= '0;
      disc_head_q <= '0;
      tail_q <= '0;
      highest_q <= '0;
      started_q <= 1'b0;
      wraps_q <= '0;
      rcvd_q <= '0;
      payt_q <= '0;
      lost_q <= '0;
      dol_q <= '0;
      late_q <= '0;
      lbyt_q <= '0;
      wbytes_q <= '0;
      wpkt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_disc_q <= cfg_disc_d;
      cfg_lose_q <= cfg_lose_d;
      cfg_win_q  <= cfg_win_d;
      win_head_q <= win_head_d;
      miss_head_q <= miss_head_d;
      disc_head_q <= disc_head_d;
      tail_q <= tail_d;
      highest_q <= highest_d;
      started_q <= started_d;
      wraps_q <= wraps_d;
      rcvd_q <= rcvd_d;
      payt_q <= payt_d;
      lost_q <= lost_d;
      dol_q <= dol_d;
      late_q <= late_d;
      lbyt_q <= lbyt_d;
      wbytes_q <= wbytes_d;
      wpkt_q <= wpkt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/rtp_receive_loss_tracker.sv -----
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    tuser opcode; tdata seq, payload, time
// m_axis   out  m_axis_tvalid/m_axis_tready    tdata report fields
// cfg      in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// One request at a time. A clear goes straight to its report; a late arrival searches the
// missed, then the discarded entries for its sequence; an in-order packet steps the discard,
// miss and window aging scans, then pushes each gap entry and itself, forcing out the oldest
// entry first whenever the ring is full. Reset clears pointers and counters and loads the
// default limits; the entry RAM needs no clearing.
// A finished report waits in the output register while the next request is taken.
module rtp_receive_loss_tracker
  import rlt_pkg::*;
#(
  parameter int unsigned TRACK_DEPTH = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] opcode
  input  logic                s_axis_tuser,
  // [15:0] sequence_number, [31:16] pay_len, [79:32] arrival_time_us
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] highest, [47:16] wraps, [79:48] received, [111:80] payload,
  // [128:112] window_packets, [160:129] window_bytes, [192:161] lost,
  // [224:193] discarded_or_lost, [256:225] late_discarded, [288:257] late_bytes
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  cmd_e        cmd;
  rlt_status_t st;

  assign cfg_ready_o = 1'b1;

  rlt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rlt_datapath #(
    .TRACK_DEPTH (TRACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import rlt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 4096;
  localparam int StallLimit = 1000000;
  localparam logic [TimeW-1:0] TimeTop = 48'hFFFF_FFFF_FFFF;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [SeqW-1:0]  highest;
    logic [CntW-1:0]  wraps;
    logic [CntW-1:0]  received;
    logic [CntW-1:0]  payload;
    logic [WpktW-1:0] win_pkts;
    logic [CntW-1:0]  win_bytes;
    logic [CntW-1:0]  lost;
    logic [CntW-1:0]  disc_or_lost;
    logic [CntW-1:0]  late_disc;
    logic [CntW-1:0]  late_bytes;
  } loss_report_t;

  typedef struct {
    bit               clear;
    logic [SeqW-1:0]  seq;
    logic [PayW-1:0]  pay;
    logic [TimeW-1:0] dt;
    bit               typed;
    loss_report_t     want;
  } arrival_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic s_axis_tuser = 1'b0;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  rtp_receive_loss_tracker dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // tracker shadow state
  logic [TimeW-1:0] ent_time [Depth];
  logic [InfoW-1:0] ent_info [Depth];
  longint unsigned win_head, miss_head, disc_head, tail_pos;
  logic [SeqW-1:0] top_seq;
  bit tracking;
  logic [CntW-1:0] n_wraps, n_rcvd, n_pay, n_wpkt, n_lost, n_dol, n_late, n_lbytes;
  longint unsigned win_sum;
  logic [CfgW-1:0] lim_discard = DiscardReset;
  logic [CfgW-1:0] lim_lose = LoseReset;
  logic [CfgW-1:0] lim_window = WindowReset;

  loss_report_t expected_reports[$];
  int errors = 0;
  int burst_left = 0;
  logic [TimeW-1:0] now_us = 48'd1000;
  logic [SeqW-1:0] gen_seq;

  function automatic logic [CntW-1:0] add_sat(input logic [CntW-1:0] a, input logic [CntW-1:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CntW] ? '1 : s[CntW-1:0];
  endfunction

  function automatic bit is_old(input logic [TimeW-1:0] t, input logic [CfgW-1:0] lim,
                                input logic [TimeW-1:0] now);
    return (longint'(t) + longint'(lim)) < longint'(now);
  endfunction

  function automatic bit is_good(input logic [InfoW-1:0] info);
    return !info[FlMiss] && !info[FlDisc];
  endfunction

  function automatic void leave_window(input logic [InfoW-1:0] info);
    longint unsigned p;
    p = 64'(info[31:16]);
    if (!is_good(info)) return;
    if (n_wpkt > 0) n_wpkt--;
    win_sum = (win_sum >= p) ? win_sum - p : 0;
  endfunction

  function automatic void clear_tracking();
    {n_wraps, n_rcvd, n_pay, n_wpkt, n_lost, n_dol, n_late, n_lbytes} = '0;
    win_sum = 0;
    top_seq = '0;
    tracking = 0;
    win_head = tail_pos;
    miss_head = tail_pos;
    disc_head = tail_pos;
  endfunction

  function automatic void age_ring(input logic [TimeW-1:0] now);
    int i;
    while (disc_head < tail_pos) begin
      i = int'(disc_head % Depth);
      if (ent_info[i][FlDisc]) begin
        if (!ent_info[i][FlRcv]) begin
          if (!is_old(ent_time[i], lim_lose, now)) break;
          ent_info[i][FlLost] = 1'b1;
          n_lost = add_sat(n_lost, 1);
        end
      end else if (ent_info[i][FlMiss] && !ent_info[i][FlRcv]) begin
        break;
      end
      disc_head++;
    end
    while (miss_head < tail_pos) begin
      i = int'(miss_head % Depth);
      if (ent_info[i][FlMiss] && !ent_info[i][FlDisc] && !ent_info[i][FlRcv]) begin
        if (!is_old(ent_time[i], lim_discard, now)) break;
        ent_info[i][FlDisc] = 1'b1;
        n_dol = add_sat(n_dol, 1);
      end
      miss_head++;
    end
    while (win_head < tail_pos) begin
      i = int'(win_head % Depth);
      if (!is_old(ent_time[i], lim_window, now)) break;
      leave_window(ent_info[i]);
      win_head++;
    end
  endfunction

  function automatic longint unsigned oldest_pos();
    longint unsigned m;
    m = win_head;
    if (miss_head < m) m = miss_head;
    if (disc_head < m) m = disc_head;
    return m;
  endfunction

  function automatic void store_entry(input logic [TimeW-1:0] now, input logic [InfoW-1:0] info);
    longint unsigned start;
    int i;
    start = oldest_pos();
    if (tail_pos - start >= Depth) begin
      // ring full: push out the oldest entry
      i = int'(start % Depth);
      if (win_head == start) begin
        leave_window(ent_info[i]);
        win_head++;
      end
      if (miss_head == start) begin
        if (ent_info[i][FlMiss] && !ent_info[i][FlDisc] && !ent_info[i][FlRcv]) begin
          ent_info[i][FlDisc] = 1'b1;
          n_dol = add_sat(n_dol, 1);
        end
        miss_head++;
      end
      if (disc_head == start) begin
        if (ent_info[i][FlDisc] && !ent_info[i][FlRcv] && !ent_info[i][FlLost]) begin
          ent_info[i][FlLost] = 1'b1;
          n_lost = add_sat(n_lost, 1);
        end
        disc_head++;
      end
    end
    i = int'(tail_pos % Depth);
    ent_time[i] = now;
    ent_info[i] = info;
    tail_pos++;
  endfunction

  function automatic void store_good(input logic [TimeW-1:0] now, input logic [SeqW-1:0] seq,
                                     input logic [PayW-1:0] pay);
    logic [InfoW-1:0] info;
    info = {4'b0001, pay, seq};
    store_entry(now, info);
    if (n_wpkt != '1) n_wpkt++;
    win_sum += 64'(pay);
  endfunction

  function automatic void match_late(input logic [SeqW-1:0] seq, input logic [PayW-1:0] pay);
    int i;
    for (longint unsigned p = miss_head; p < tail_pos; p++) begin
      i = int'(p % Depth);
      if (ent_info[i][FlMiss] && !ent_info[i][FlDisc] && ent_info[i][15:0] == seq) begin
        ent_info[i][31:16] = pay;
        ent_info[i][FlRcv] = 1'b1;
        return;
      end
    end
    for (longint unsigned p = disc_head; p < tail_pos; p++) begin
      i = int'(p % Depth);
      if (ent_info[i][FlDisc] && ent_info[i][15:0] == seq) begin
        ent_info[i][31:16] = pay;
        ent_info[i][FlRcv] = 1'b1;
        n_late = add_sat(n_late, 1);
        n_lbytes = add_sat(n_lbytes, 32'(pay));
        return;
      end
    end
  endfunction

  function automatic loss_report_t track_arrival(input bit clear, input logic [SeqW-1:0] seq,
                                                 input logic [PayW-1:0] pay,
                                                 input logic [TimeW-1:0] now);
    loss_report_t r;
    logic [SeqW-1:0] fwd;
    logic [InfoW-1:0] info;
    if (clear) begin
      clear_tracking();
    end else begin
      n_rcvd = add_sat(n_rcvd, 1);
      n_pay = add_sat(n_pay, 32'(pay));
      if (!tracking) begin
        tracking = 1;
        age_ring(now);
        store_good(now, seq, pay);
        top_seq = seq;
      end else begin
        fwd = seq - top_seq;
        if (fwd == 0 || fwd >= 16'd32768) begin
          match_late(seq, pay);
        end else begin
          age_ring(now);
          for (int k = 1; k < fwd; k++) begin
            info = '0;
            info[15:0] = top_seq + k[SeqW-1:0];
            if (lim_discard > 0) begin
              info[FlMiss] = 1'b1;
            end else begin
              info[FlDisc] = 1'b1;
              n_dol = add_sat(n_dol, 1);
            end
            store_entry(now, info);
          end
          store_good(now, seq, pay);
          if (top_seq > WrapHigh && seq < WrapLow) n_wraps = add_sat(n_wraps, 1);
          top_seq = seq;
        end
      end
    end
    r.highest = top_seq;
    r.wraps = n_wraps;
    r.received = n_rcvd;
    r.payload = n_pay;
    r.win_pkts = n_wpkt[WpktW-1:0];
    r.win_bytes = (win_sum > 64'hFFFF_FFFF) ? '1 : win_sum[CntW-1:0];
    r.lost = n_lost;
    r.disc_or_lost = n_dol;
    r.late_disc = n_late;
    r.late_bytes = n_lbytes;
    return r;
  endfunction

  task automatic send_arrival(input bit clear, input logic [SeqW-1:0] seq,
                              input logic [PayW-1:0] pay, input logic [TimeW-1:0] now,
                              input bit typed = 1'b0, input loss_report_t want = '0);
    loss_report_t pred;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= clear;
    s_axis_tdata <= {now, pay, seq};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = track_arrival(clear, seq, pay, now);
    expected_reports.push_back(typed ? want : pred);
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DISCARD: lim_discard = value;
      REG_LOSE:    lim_lose = value;
      REG_WINDOW:  lim_window = value;
      default: ;
    endcase
  endtask

  task automatic random_arrivals(input int count, input int step);
    int r;
    bit clear;
    logic [SeqW-1:0] seq;
    logic [SeqW-1:0] fwd;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      clear = 0;
      if (r < 60) seq = gen_seq + 16'd1;
      else if (r < 75) seq = gen_seq + SeqW'($urandom_range(2, 6));
      else if (r < 85) seq = gen_seq - SeqW'($urandom_range(0, 20));
      else if (r < 88) seq = gen_seq + SeqW'($urandom_range(100, 1500));
      else if (r < 89) seq = gen_seq + SeqW'($urandom_range(4097, 6000));
      else if (r < 91) seq = gen_seq + 16'd32768;
      else if (r < 93) clear = 1;
      else seq = SeqW'($urandom_range(0, 65535));
      if (clear) seq = SeqW'($urandom_range(0, 65535));
      fwd = seq - gen_seq;
      if (!clear && fwd != 0 && fwd < 16'd32768) gen_seq = seq;
      if ($urandom_range(0, 3) != 0) now_us += TimeW'($urandom_range(0, step));
      if ($urandom_range(0, 30) == 0) now_us += TimeW'($urandom_range(0, 2000000));
      case ($urandom_range(0, 9))
        0: send_arrival(clear, seq, '0, now_us);
        1: send_arrival(clear, seq, '1, now_us);
        default: send_arrival(clear, seq, PayW'($urandom_range(0, 65535)), now_us);
      endcase
    end
  endtask

  // receiver: always ready for a while, then stall at random
  int rx_cycle = 0;
  always @(posedge clk_i) begin
    loss_report_t exp_r, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[OutW-1:0];
      got = {got.late_bytes, got.late_disc, got.disc_or_lost, got.lost, got.win_bytes,
             got.win_pkts, got.payload, got.received, got.wraps, got.highest};
      got.highest = m_axis_tdata[15:0];
      got.wraps = m_axis_tdata[47:16];
      got.received = m_axis_tdata[79:48];
      got.payload = m_axis_tdata[111:80];
      got.win_pkts = m_axis_tdata[128:112];
      got.win_bytes = m_axis_tdata[160:129];
      got.lost = m_axis_tdata[192:161];
      got.disc_or_lost = m_axis_tdata[224:193];
      got.late_disc = m_axis_tdata[256:225];
      got.late_bytes = m_axis_tdata[288:257];
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_reports.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t report mismatch", $realtime);
          $display("  highest      exp %0d got %0d", exp_r.highest, got.highest);
          $display("  wraps        exp %0d got %0d", exp_r.wraps, got.wraps);
          $display("  received     exp %0d got %0d", exp_r.received, got.received);
          $display("  payload      exp %0d got %0d", exp_r.payload, got.payload);
          $display("  win_pkts     exp %0d got %0d", exp_r.win_pkts, got.win_pkts);
          $display("  win_bytes    exp %0d got %0d", exp_r.win_bytes, got.win_bytes);
          $display("  lost         exp %0d got %0d", exp_r.lost, got.lost);
          $display("  disc_or_lost exp %0d got %0d", exp_r.disc_or_lost, got.disc_or_lost);
          $display("  late_disc    exp %0d got %0d", exp_r.late_disc, got.late_disc);
          $display("  late_bytes   exp %0d got %0d", exp_r.late_bytes, got.late_bytes);
        end
      end
    end
    rx_cycle++;
    m_axis_tready <= (rx_cycle % 256 < 96) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  arrival_row_t directed[] = '{
    '{1, 16'd0,     16'd0,     48'd0,       1, '0},  // clear after reset
    '{0, 16'd65530, 16'd0,     48'd0,       1,        // first packet
      '{16'd65530, '0, 32'd1, '0, 17'd1, '0, '0, '0, '0, '0}},
    '{0, 16'd65531, 16'hFFFF,  48'd10,      0, '0},
    '{0, 16'd65531, 16'd5,     48'd10,      0, '0},  // duplicate of highest
    '{0, 16'd65535, 16'd100,   48'd100,     0, '0},
    '{0, 16'd2,     16'd200,   48'd100,     0, '0},  // wrap with gap
    '{0, 16'd65533, 16'd300,   48'd100,     0, '0},  // late, fills a missed entry
    '{0, 16'd32770, 16'd7,     48'd100,     0, '0},  // exactly half range away
    '{0, 16'd3,     16'd11,    48'd400000,  0, '0},  // misses age to discarded
    '{0, 16'd0,     16'd4321,  48'd10,      0, '0},  // late after discard
    '{0, 16'd4,     16'd12,    48'd1100000, 0, '0},  // discards age to lost
    '{0, 16'd5004,  16'd13,    48'd10,      0, '0},  // gap beyond ring depth
    '{0, 16'd37771, 16'd14,    48'd10,      0, '0},  // largest forward gap
    '{0, 16'd37771, 16'd15,    48'd0,       0, '0},
    '{1, 16'hFFFF,  16'hFFFF,  48'd5,       1, '0},  // clear shows all zero
    '{0, 16'd0,     16'd7,     48'd5,       0, '0},
    '{0, 16'd1,     16'd1,     48'd5,       0, '0}
  };

  initial begin
    clear_tracking();
    tail_pos = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      now_us += directed[i].dt;
      send_arrival(directed[i].clear, directed[i].seq, directed[i].pay, now_us,
                   directed[i].typed, directed[i].want);
    end
    gen_seq = top_seq;
    random_arrivals(140, 150000);
    drain();

    write_reg(REG_DISCARD, '0);
    write_reg(REG_LOSE, '0);
    write_reg(REG_WINDOW, 24'd1);
    write_reg(RegUnused, '1);
    random_arrivals(130, 50);
    drain();

    write_reg(REG_DISCARD, '1);
    write_reg(REG_LOSE, '1);
    write_reg(REG_WINDOW, '1);
    random_arrivals(130, 200000);
    drain();

    write_reg(REG_DISCARD, CfgW'($urandom_range(1000, 50000)));
    write_reg(REG_LOSE, CfgW'($urandom_range(0, 200000)));
    write_reg(REG_WINDOW, CfgW'($urandom_range(1, 100000)));
    random_arrivals(130, 20000);

    // latest possible arrival times
    now_us = TimeTop - 48'd20;
    random_arrivals(8, 2);
    now_us = TimeTop;
    send_arrival(0, gen_seq + 16'd1, 16'hFFFF, now_us);
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rlt_pkg.sv
rtl/rlt_ctrl.sv
rtl/rlt_datapath.sv
rtl/rtp_receive_loss_tracker.sv
verif/testbench.sv
